// File: hw/rtl/framed_mode_command_parser_macros.svh
`ifndef FRAMED_MODE_COMMAND_PARSER_MACROS_SVH
`define FRAMED_MODE_COMMAND_PARSER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define FMCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FMCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fmcp_pkg.sv
package fmcp_pkg;

    localparam logic [1:0] ACT_RX   = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_TAKE = 2'd2;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'h55;
    localparam logic [7:0] TAIL_FIRST  = 8'h55;
    localparam logic [7:0] TAIL_SECOND = 8'hAA;
    localparam logic [7:0] MENU_COUNT  = 8'd8;

    // 2*m minus these gives the slide offset above / below the menu count
    localparam logic [9:0] SLIDE_HI_BIAS = 10'd6;
    localparam logic [9:0] SLIDE_LO_BIAS = 10'd26;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_READ = 2'd1,
        OP_TAKE = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
        logic [6:0] payload_index;
    } q_item_t;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_HDR2  = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TAIL1 = 5'b01000,
        PH_TAIL2 = 5'b10000
    } phase_t;

    function automatic logic signed [9:0] slide_for(input logic [7:0] m);
        logic [9:0] dbl;
        dbl = {1'b0, m, 1'b0};
        if (m > MENU_COUNT)
        begin
            return signed'(dbl - SLIDE_HI_BIAS);
        end
        else if (m < MENU_COUNT)
        begin
            return signed'(dbl - SLIDE_LO_BIAS);
        end
        return '0;
    endfunction

endpackage

// File: hw/rtl/fmcp_in_if.sv
interface fmcp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [6:0] payload_index;

    modport source (output valid, output action, output rx_byte, output payload_index,
                    input ready);
    modport sink (input valid, input action, input rx_byte, input payload_index,
                  output ready);
endinterface

// File: hw/rtl/fmcp_out_if.sv
interface fmcp_out_if;
    logic              valid;
    logic              ready;
    logic              frame_done;
    logic              mode_changed;
    logic [7:0]        current_mode;
    logic signed [9:0] slide_offset;
    logic [7:0]        payload_byte;
    logic              payload_ready;

    modport source (output valid, output frame_done, output mode_changed,
                    output current_mode, output slide_offset, output payload_byte,
                    output payload_ready, input ready);
    modport sink (input valid, input frame_done, input mode_changed,
                  input current_mode, input slide_offset, input payload_byte,
                  input payload_ready, output ready);
endinterface

// File: hw/rtl/framed_mode_command_parser.sv
// An accepted item is written into the queue, then processed and its result held in the
//   output register until it is taken.
// Throughput: one item per cycle while results are taken; a 2-entry queue and the output register decouple sides.
// Reset (rst_n, async, active low): parser hunts for a header, ready flag, mode,
//   offset and link enable cleared; the payload store is not cleared.
module framed_mode_command_parser
    import fmcp_pkg::*;
#(
    parameter int PAYLOAD_LEN = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    fmcp_in_if.sink    cmd,
    fmcp_out_if.source rsp
);

    logic    link_en_reg;
    logic    link_en_next;
    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;

    assign link_en_next = cfg_we ? cfg_wdata : link_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_en_reg <= 1'b0;
        end
        else
        begin
            link_en_reg <= link_en_next;
        end
    end

    fmcp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .link_en (link_en_reg),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    fmcp_back #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .rsp     (rsp)
    );

endmodule

// File: hw/rtl/fmcp_front.sv
module fmcp_front
    import fmcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    link_en,
    fmcp_in_if.sink cmd,
    output logic    q_valid,
    input  logic    q_ready,
    output q_item_t q_item
);

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    q_item_t    cls_item;

    // classify: a received byte with the link off is a no-op
    always_comb
    begin
        cls_item.rx_byte       = cmd.rx_byte;
        cls_item.payload_index = cmd.payload_index;
        unique case (cmd.action)
            ACT_RX:   cls_item.op = link_en ? OP_RX : OP_NOP;
            ACT_READ: cls_item.op = OP_READ;
            ACT_TAKE: cls_item.op = OP_TAKE;
            default:  cls_item.op = OP_NOP;
        endcase
    end

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

// File: hw/rtl/fmcp_back.sv
module fmcp_back
    import fmcp_pkg::*;
#(
    parameter int PAYLOAD_LEN = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  q_item_t    q_item,
    fmcp_out_if.source rsp
);

    `include "framed_mode_command_parser_macros.svh"

    localparam int         AW   = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam logic [8:0] LEN9 = 9'(PAYLOAD_LEN);

    logic [7:0]        mem [PAYLOAD_LEN];

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [7:0]        cnt_reg;
    logic [7:0]        cnt_next;
    logic              rdy_reg;
    logic              rdy_next;
    logic [7:0]        mode_reg;
    logic [7:0]        mode_next;
    logic signed [9:0] offset_reg;
    logic signed [9:0] offset_next;
    logic [7:0]        first_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              done_reg;
    logic              done_next;
    logic              chg_reg;
    logic              chg_next;
    logic              rdy_before_reg;
    logic              rd_hit_reg;
    logic              rd_hit_next;
    logic [7:0]        rd_data_reg;

    logic              adv;
    logic              wr_en;
    logic [7:0]        idx_ext;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        b;

    assign b       = q_item.rx_byte;
    assign q_ready = !out_valid_reg || rsp.ready;
    assign adv     = q_valid && q_ready;
    assign idx_ext = {1'b0, q_item.payload_index};
    assign rd_addr = idx_ext[AW-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        rdy_next    = rdy_reg;
        mode_next   = mode_reg;
        offset_next = offset_reg;
        done_next   = 1'b0;
        chg_next    = 1'b0;
        wr_en       = 1'b0;
        rd_hit_next = (q_item.op == OP_READ) && ({1'b0, idx_ext} < LEN9);
        if (adv)
        begin
            unique case (q_item.op)
                OP_RX:
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (b == HDR_FIRST)
                            begin
                                phase_next = PH_HDR2;
                            end
                        end
                        PH_HDR2:
                        begin
                            // repeated header byte keeps waiting here
                            if (b == HDR_SECOND)
                            begin
                                phase_next = PH_DATA;
                                cnt_next   = '0;
                            end
                            else if (b != HDR_FIRST)
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_DATA:
                        begin
                            wr_en    = ({1'b0, cnt_reg} < LEN9);
                            cnt_next = cnt_reg + 8'd1;
                            if ({1'b0, cnt_next} >= LEN9)
                            begin
                                phase_next = PH_TAIL1;
                            end
                        end
                        PH_TAIL1:
                        begin
                            phase_next = (b == TAIL_FIRST) ? PH_TAIL2 : PH_HUNT;
                        end
                        PH_TAIL2:
                        begin
                            if (b == TAIL_SECOND)
                            begin
                                rdy_next  = 1'b1;
                                done_next = 1'b1;
                                if (first_reg != mode_reg)
                                begin
                                    chg_next    = 1'b1;
                                    mode_next   = first_reg;
                                    offset_next = slide_for(first_reg);
                                end
                            end
                            phase_next = PH_HUNT;
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
                OP_TAKE:
                begin
                    rdy_next = 1'b0;
                end
                OP_READ:
                begin
                end
                OP_NOP:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            cnt_reg        <= '0;
            rdy_reg        <= 1'b0;
            mode_reg       <= '0;
            offset_reg     <= '0;
            out_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            chg_reg        <= 1'b0;
            rdy_before_reg <= 1'b0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            rdy_reg       <= rdy_next;
            mode_reg      <= mode_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                done_reg       <= done_next;
                chg_reg        <= chg_next;
                rdy_before_reg <= rdy_reg;
                rd_hit_reg     <= rd_hit_next;
            end
        end
    end

    // payload store; byte 0 also kept aside for the mode check at the tail
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[AW-1:0]] <= b;
        end
        if (wr_en && (cnt_reg == 8'd0))
        begin
            first_reg <= b;
        end
        if (adv)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.frame_done    = done_reg;
    assign rsp.mode_changed  = chg_reg;
    assign rsp.current_mode  = mode_reg;
    assign rsp.slide_offset  = offset_reg;
    assign rsp.payload_byte  = rd_hit_reg ? rd_data_reg : 8'd0;
    assign rsp.payload_ready = rdy_before_reg;

    `FMCP_ASSERT(a_chg_needs_done, rsp.valid && rsp.mode_changed |-> rsp.frame_done, "mode change without frame")
    `FMCP_ASSERT(a_done_sets_ready, rsp.valid && rsp.frame_done |-> rdy_reg, "frame done but ready flag clear")
    `FMCP_ASSERT(a_take_clears, adv && (q_item.op == OP_TAKE) |=> !rdy_reg, "take left ready flag set")
    `FMCP_ASSERT_ALWAYS(a_cnt_in_range, (phase_reg == PH_DATA) |-> ({1'b0, cnt_reg} < LEN9), "byte count past payload")

endmodule

// File: dv/tb_framed_mode_command_parser.sv
module tb_framed_mode_command_parser
    import fmcp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN   = 128;
    localparam int ITEMS       = 2000;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic              done;
        logic              changed;
        logic [7:0]        mode;
        logic signed [9:0] offset;
        logic [7:0]        pbyte;
        logic              pready;
    } reply_t;

    typedef struct packed {
        logic       link;
        op_t        op;
        logic [7:0] b;
        logic [6:0] ix;
        logic       typed;
        reply_t     want;
    } step_row_t;

    typedef enum {
        FR_GOOD,
        FR_REPEAT_HDR,
        FR_BAD_TAIL1,
        FR_BAD_TAIL2,
        FR_BAD_HDR
    } frame_kind_t;

    localparam reply_t QUIET_REPLY = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fmcp_in_if  cmd_if ();
    fmcp_out_if rsp_if ();

    framed_mode_command_parser #(.PAYLOAD_LEN(FRAME_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_if),
        .rsp       (rsp_if)
    );

    // parser state as the block should hold it
    logic              link_on;
    phase_t            hunt_phase;
    logic [7:0]        data_count;
    logic [7:0]        store [FRAME_LEN];
    bit                written [FRAME_LEN];
    logic              flag_ready;
    logic [7:0]        mode_held;
    logic signed [9:0] offset_held;

    reply_t awaited_replies [$];

    int  mismatches;
    int  results_seen;
    int  items_done;
    int  frames_seen;
    int  mode_switches;
    int  link_writes;
    bit  steady;
    bit  hold_req;
    bit  hold_spent;

    // link off: everything reads zero; link on: header tracking, still no frame
    step_row_t plan [19] = '{
        '{1'b0, OP_TAKE, 8'h00, 7'h00, 1'b1, QUIET_REPLY},
        '{1'b0, OP_NOP,  8'hFF, 7'h7F, 1'b1, QUIET_REPLY},
        '{1'b0, OP_RX,   8'hAA, 7'h7F, 1'b1, QUIET_REPLY},
        '{1'b0, OP_RX,   8'h55, 7'h00, 1'b1, QUIET_REPLY},
        '{1'b0, OP_RX,   8'h00, 7'h55, 1'b1, QUIET_REPLY},
        '{1'b0, OP_RX,   8'hFF, 7'h2A, 1'b1, QUIET_REPLY},
        '{1'b0, OP_NOP,  8'h00, 7'h00, 1'b1, QUIET_REPLY},
        '{1'b1, OP_RX,   8'h00, 7'h00, 1'b1, QUIET_REPLY},
        '{1'b1, OP_RX,   8'hFF, 7'h7F, 1'b1, QUIET_REPLY},
        '{1'b1, OP_RX,   8'hAA, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_RX,   8'h00, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_RX,   8'hAA, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_RX,   8'hAA, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_RX,   8'h13, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_TAKE, 8'hFF, 7'h7F, 1'b1, QUIET_REPLY},
        '{1'b1, OP_NOP,  8'hAA, 7'h55, 1'b1, QUIET_REPLY},
        '{1'b1, OP_RX,   8'hAA, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_RX,   8'h7F, 7'h00, 1'b0, QUIET_REPLY},
        '{1'b1, OP_RX,   8'h55, 7'h00, 1'b1, QUIET_REPLY}
    };

    frame_kind_t opening_kinds [9] = '{FR_GOOD, FR_REPEAT_HDR, FR_BAD_TAIL1, FR_BAD_TAIL2,
                                       FR_GOOD, FR_GOOD, FR_GOOD, FR_GOOD, FR_BAD_HDR};
    logic [7:0]  opening_modes [9] = '{8'd8, 8'd255, 8'd3, 8'd4, 8'd0, 8'd0, 8'd7, 8'd9, 8'd1};

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic reply_t next_reply(op_t op, logic [7:0] b, logic [6:0] ix);
        reply_t r;
        int     slide;
        r = '0;
        r.pready = flag_ready;
        case (op)
            OP_RX:
            begin
                if (link_on)
                begin
                    case (hunt_phase)
                        PH_HUNT:
                        begin
                            if (b == HDR_FIRST)
                                hunt_phase = PH_HDR2;
                        end
                        PH_HDR2:
                        begin
                            if (b == HDR_SECOND)
                            begin
                                hunt_phase = PH_DATA;
                                data_count = '0;
                            end
                            else if (b != HDR_FIRST)
                                hunt_phase = PH_HUNT;
                        end
                        PH_DATA:
                        begin
                            store[data_count[6:0]] = b;
                            written[data_count[6:0]] = 1'b1;
                            data_count = data_count + 8'd1;
                            if (data_count >= FRAME_LEN)
                                hunt_phase = PH_TAIL1;
                        end
                        PH_TAIL1:
                        begin
                            hunt_phase = (b == TAIL_FIRST) ? PH_TAIL2 : PH_HUNT;
                        end
                        PH_TAIL2:
                        begin
                            if (b == TAIL_SECOND)
                            begin
                                flag_ready = 1'b1;
                                r.done = 1'b1;
                                frames_seen++;
                                if (store[0] != mode_held)
                                begin
                                    r.changed = 1'b1;
                                    mode_held = store[0];
                                    mode_switches++;
                                    if (mode_held > MENU_COUNT)
                                        slide = 10 + 2 * (int'(mode_held) - int'(MENU_COUNT));
                                    else if (mode_held < MENU_COUNT)
                                        slide = -10 - 2 * (int'(MENU_COUNT) - int'(mode_held));
                                    else
                                        slide = 0;
                                    offset_held = slide[9:0];
                                end
                            end
                            hunt_phase = PH_HUNT;
                        end
                        default:
                        begin
                            hunt_phase = PH_HUNT;
                        end
                    endcase
                end
            end
            OP_READ:
            begin
                r.pbyte = store[ix];
            end
            OP_TAKE:
            begin
                flag_ready = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.mode = mode_held;
        r.offset = offset_held;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < 20)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic offer(op_t op, logic [7:0] b, logic [6:0] ix, logic typed, reply_t want);
        reply_t r;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.action        <= op;
        cmd_if.rx_byte       <= b;
        cmd_if.payload_index <= ix;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        if (op != OP_RX || link_on)
            items_done++;
        r = next_reply(op, b, ix);
        awaited_replies.push_back(typed ? want : r);
    endtask

    task automatic send(op_t op, logic [7:0] b, logic [6:0] ix);
        offer(op, b, ix, 1'b0, QUIET_REPLY);
    endtask

    task automatic send_rx(logic [7:0] b);
        send(OP_RX, b, 7'($urandom_range(0, 127)));
    endtask

    // reads only entries already filled since reset
    task automatic send_read();
        int ix;
        int k;
        ix = $urandom_range(0, FRAME_LEN - 1);
        for (k = 0; k < FRAME_LEN && !written[ix]; k++)
            ix = (ix + 1) % FRAME_LEN;
        if (written[ix])
            send(OP_READ, any_byte(), 7'(ix));
        else
            send(OP_TAKE, any_byte(), 7'($urandom_range(0, 127)));
    endtask

    task automatic maybe_aside(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            case ($urandom_range(0, 2))
                0: send_read();
                1: send(OP_TAKE, any_byte(), 7'($urandom_range(0, 127)));
                default: send(OP_NOP, any_byte(), 7'($urandom_range(0, 127)));
            endcase
        end
    endtask

    task automatic send_noise(int n);
        int k;
        repeat (n)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
                send_rx(any_byte());
            else if (k == 4)
                send_rx(HDR_FIRST);
            else if (k == 5)
                send_rx(HDR_SECOND);
            else
                maybe_aside(100);
        end
    endtask

    task automatic send_frame(frame_kind_t kind, logic [7:0] m);
        logic [7:0] b;
        int         k;
        send_rx(HDR_FIRST);
        if (kind == FR_REPEAT_HDR)
        begin
            repeat ($urandom_range(1, 3))
                send_rx(HDR_FIRST);
        end
        if (kind == FR_BAD_HDR)
        begin
            do
                b = any_byte();
            while (b == HDR_SECOND || b == HDR_FIRST);
            send_rx(b);
            return;
        end
        maybe_aside(10);
        send_rx(HDR_SECOND);
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            maybe_aside(6);
            k = $urandom_range(0, 7);
            if (i == 0)
                b = m;
            else if (k == 0)
                b = HDR_FIRST;
            else if (k == 1)
                b = HDR_SECOND;
            else
                b = any_byte();
            send_rx(b);
        end
        if (kind == FR_BAD_TAIL1)
        begin
            if ($urandom_range(0, 1) == 0)
                b = HDR_FIRST;
            else
            begin
                do
                    b = any_byte();
                while (b == TAIL_FIRST);
            end
            send_rx(b);
            // a bad tail byte that looks like a header start must not open a frame
            if (b == HDR_FIRST)
            begin
                send_rx(HDR_SECOND);
                repeat (3)
                    send_rx(any_byte());
            end
            return;
        end
        send_rx(TAIL_FIRST);
        maybe_aside(10);
        if (kind == FR_BAD_TAIL2)
        begin
            do
                b = any_byte();
            while (b == TAIL_SECOND);
            send_rx(b);
        end
        else
            send_rx(TAIL_SECOND);
        maybe_aside(30);
    endtask

    task automatic set_link(logic v);
        cmd_if.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        link_on = v;
        link_writes++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : stimulus
        int         r;
        logic [7:0] m;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.action        <= OP_NOP;
        cmd_if.rx_byte       <= '0;
        cmd_if.payload_index <= '0;
        link_on       = 1'b0;
        hunt_phase    = PH_HUNT;
        data_count    = '0;
        flag_ready    = 1'b0;
        mode_held     = '0;
        offset_held   = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        hold_spent    = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        items_done    = 0;
        frames_seen   = 0;
        mode_switches = 0;
        link_writes   = 0;
        foreach (written[i])
            written[i] = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_link(1'b0);
        foreach (plan[i])
        begin
            if (plan[i].link != link_on)
                set_link(plan[i].link);
            offer(plan[i].op, plan[i].b, plan[i].ix, plan[i].typed, plan[i].want);
        end

        foreach (opening_kinds[i])
            send_frame(opening_kinds[i], opening_modes[i]);

        while (items_done < ITEMS)
        begin
            if (items_done >= 700 && !hold_spent)
            begin
                hold_req   = 1'b1;
                hold_spent = 1'b1;
            end
            steady = (items_done >= 1200 && items_done < 1500);
            if (items_done >= 1000 && link_writes == 2)
            begin
                // link off: a whole frame and noise must leave the parser alone
                set_link(1'b0);
                send_frame(FR_GOOD, any_byte());
                send_noise(20);
                set_link(1'b1);
            end
            m = ($urandom_range(0, 9) < 3) ? mode_held : any_byte();
            r = $urandom_range(0, 99);
            if (r < 55)
                send_frame(FR_GOOD, m);
            else if (r < 63)
                send_frame(FR_REPEAT_HDR, m);
            else if (r < 71)
                send_frame(FR_BAD_TAIL1, m);
            else if (r < 79)
                send_frame(FR_BAD_TAIL2, m);
            else if (r < 85)
                send_frame(FR_BAD_HDR, m);
            else
                send_noise($urandom_range(1, 12));
        end
        steady = 1'b0;
        cmd_if.valid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        $display("covered %0d items and %0d results: %0d frames completed, %0d mode switches",
                 items_done, results_seen, frames_seen, mode_switches);
        $display("with %0d link writes, aborted frames, payload reads and a %0d-cycle output hold",
                 link_writes, HOLD_CYCLES);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : result_sink
        reply_t got;
        reply_t want;
        int     hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                got.done    = rsp_if.frame_done;
                got.changed = rsp_if.mode_changed;
                got.mode    = rsp_if.current_mode;
                got.offset  = rsp_if.slide_offset;
                got.pbyte   = rsp_if.payload_byte;
                got.pready  = rsp_if.payload_ready;
                if (awaited_replies.size() == 0)
                    report_mismatch("result with nothing awaited");
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.done !== want.done)
                        report_mismatch($sformatf("frame_done %0b, want %0b",
                                                  got.done, want.done));
                    if (got.changed !== want.changed)
                        report_mismatch($sformatf("mode_changed %0b, want %0b",
                                                  got.changed, want.changed));
                    if (got.mode !== want.mode)
                        report_mismatch($sformatf("current_mode %0d, want %0d",
                                                  got.mode, want.mode));
                    if (got.offset !== want.offset)
                        report_mismatch($sformatf("slide_offset %0d, want %0d",
                                                  got.offset, want.offset));
                    if (got.pbyte !== want.pbyte)
                        report_mismatch($sformatf("payload_byte %0d, want %0d",
                                                  got.pbyte, want.pbyte));
                    if (got.pready !== want.pready)
                        report_mismatch($sformatf("payload_ready %0b, want %0b",
                                                  got.pready, want.pready));
                end
                results_seen++;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                rsp_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_req = 1'b0;
            end
            else
                rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
